>>> rtl/core/assert_macros.svh
// Assertion macros shared by the decimal text parser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge of clk outside reset
`define DTFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dtfp: assertion failed");
// Check that a condition implies another at the following clock edge
`define DTFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtfp: assertion failed");
`else
`define DTFP_ASSERT(lbl, prop)
`define DTFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/dtfp_pkg.sv
// Types, codes and constant tables of the decimal text to fixed point unit
package dtfp_pkg;

  localparam int unsigned FRAC_W  = 30;  // holds 10^9 - 1
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned OUT_W   = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef enum logic [1:0] {
    CLS_NUL,
    CLS_POINT,
    CLS_DIGIT,
    CLS_OTHER
  } dtfp_cls_t;

  // One finished string handed from the parser to the converter
  typedef struct packed {
    logic [OUT_W-1:0]  int_part;
    logic [FRAC_W-1:0] frac_accum;
    logic [CNT_W-1:0]  frac_count;
    logic              bad;
    logic              ovf;
  } dtfp_rec_t;

  // Fields that ride along the divider pipeline untouched
  typedef struct packed {
    logic [OUT_W-1:0] int_part;
    logic             bad;
    logic             ovf;
  } dtfp_side_t;

  function automatic logic [FRAC_W-1:0] pow10(input logic [CNT_W-1:0] n);
    logic [FRAC_W-1:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/core/dtfp_front.sv
// Byte parser: classifies characters and accumulates integer and fraction digits
`include "assert_macros.svh"
module dtfp_front import dtfp_pkg::*; #(
  parameter int unsigned INT_WIDTH   = 32,
  parameter int unsigned FRAC_DIGITS = 9
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_char_code,
  input  logic            q_room,
  output logic            q_push,
  output dtfp_rec_t       q_rec
);

  logic [INT_WIDTH-1:0]  int_accum_r, int_accum_nxt;
  logic [FRAC_W-1:0]     frac_accum_r, frac_accum_nxt;
  logic [CNT_W-1:0]      frac_count_r, frac_count_nxt;
  logic                  point_seen_r, point_seen_nxt;
  logic                  bad_r, bad_nxt;
  logic                  ovf_r, ovf_nxt;

  logic                  accept;
  dtfp_cls_t             cls;
  logic [3:0]            digit;
  logic [INT_WIDTH+3:0]  int_times10;
  logic                  int_wrap;
  logic [FRAC_W+3:0]     frac_times10;
  logic [INT_WIDTH+OUT_W-1:0] int_ext;

  assign in_ready = q_room;
  assign accept   = in_valid && in_ready;
  assign digit    = 4'(in_char_code - CH_ZERO);

  always_comb begin
    if (in_char_code == CH_NUL) begin
      cls = CLS_NUL;
    end else if (in_char_code == CH_POINT) begin
      cls = CLS_POINT;
    end else if (in_char_code >= CH_ZERO && in_char_code <= CH_NINE) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_OTHER;
    end
  end

  // a*10 + d by shift and add; any carry out of INT_WIDTH means saturation
  assign int_times10 = {1'b0, int_accum_r, 3'b000} + {3'b000, int_accum_r, 1'b0}
                     + (INT_WIDTH+4)'(digit);
  assign int_wrap    = |int_times10[INT_WIDTH+3:INT_WIDTH];
  assign frac_times10 = {1'b0, frac_accum_r, 3'b000} + {3'b000, frac_accum_r, 1'b0}
                      + (FRAC_W+4)'(digit);

  assign int_ext = {{OUT_W{1'b0}}, int_accum_r};

  always_comb begin
    q_rec.int_part   = int_ext[OUT_W-1:0];
    q_rec.frac_accum = frac_accum_r;
    q_rec.frac_count = frac_count_r;
    q_rec.bad        = bad_r;
    q_rec.ovf        = ovf_r;
  end

  assign q_push = accept && (cls == CLS_NUL);

  always_comb begin
    int_accum_nxt  = int_accum_r;
    frac_accum_nxt = frac_accum_r;
    frac_count_nxt = frac_count_r;
    point_seen_nxt = point_seen_r;
    bad_nxt        = bad_r;
    ovf_nxt        = ovf_r;
    if (accept) begin
      unique case (cls)
        CLS_NUL: begin
          int_accum_nxt  = '0;
          frac_accum_nxt = '0;
          frac_count_nxt = '0;
          point_seen_nxt = 1'b0;
          bad_nxt        = 1'b0;
          ovf_nxt        = 1'b0;
        end
        CLS_POINT: begin
          if (point_seen_r) begin
            bad_nxt = 1'b1;
          end else begin
            point_seen_nxt = 1'b1;
          end
        end
        CLS_DIGIT: begin
          if (!point_seen_r) begin
            if (int_wrap) begin
              int_accum_nxt = '1;
              ovf_nxt       = 1'b1;
            end else begin
              int_accum_nxt = int_times10[INT_WIDTH-1:0];
            end
          end else if (frac_count_r < CNT_W'(FRAC_DIGITS)) begin
            frac_accum_nxt = frac_times10[FRAC_W-1:0];
            frac_count_nxt = frac_count_r + 1'b1;
          end
        end
        CLS_OTHER: begin
          bad_nxt = 1'b1;
        end
        default: begin
          bad_nxt = bad_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_accum_r  <= '0;
      frac_accum_r <= '0;
      frac_count_r <= '0;
      point_seen_r <= 1'b0;
      bad_r        <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      int_accum_r  <= int_accum_nxt;
      frac_accum_r <= frac_accum_nxt;
      frac_count_r <= frac_count_nxt;
      point_seen_r <= point_seen_nxt;
      bad_r        <= bad_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  `DTFP_ASSERT(a_frac_count_bound, frac_count_r <= CNT_W'(FRAC_DIGITS))
  `DTFP_ASSERT(a_ovf_saturated, !ovf_r || (int_accum_r == {INT_WIDTH{1'b1}}))
  `DTFP_ASSERT_NEXT(a_cleared_after_push, q_push,
                    int_accum_r == '0 && frac_count_r == '0 && !point_seen_r && !bad_r)

endmodule

>>> rtl/core/dtfp_queue.sv
// Two-entry queue of finished strings between parser and converter
module dtfp_queue import dtfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  dtfp_rec_t push_rec,
  output logic      room,
  input  logic      pop,
  output logic      head_valid,
  output dtfp_rec_t head_rec
);

  dtfp_rec_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign room       = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_rec   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/core/dtfp_back.sv
// Converter: scales kept fraction digits and divides by 10^FRAC_DIGITS into Q0.32
`include "assert_macros.svh"
module dtfp_back import dtfp_pkg::*; #(
  parameter int unsigned FRAC_DIGITS = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  dtfp_rec_t        q_rec,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_int_part,
  output logic [OUT_W-1:0] out_frac_part,
  output logic [1:0]       out_status
);

  localparam logic [FRAC_W-1:0] DIV    = pow10(CNT_W'(FRAC_DIGITS));
  // 2^KSH covers DIV^2, so the rounded-up reciprocal truncates to the exact quotient
  localparam int unsigned       KSH    = 2 * $clog2(DIV);
  localparam int unsigned       REC_W  = 63;
  localparam int unsigned       HI_W   = REC_W - OUT_W;
  localparam int unsigned       PROD_W = FRAC_W + REC_W;
  localparam logic [127:0]      RECIP  = ((128'd1 << (OUT_W + KSH)) + 128'(DIV) - 128'd1)
                                         / 128'(DIV);
  localparam logic [OUT_W-1:0]  REC_LO = RECIP[OUT_W-1:0];
  localparam logic [HI_W-1:0]   REC_HI = RECIP[REC_W-1:OUT_W];

  logic                    adv;
  logic [CNT_W-1:0]        scale_idx;
  logic [2*FRAC_W-1:0]     scaled;
  logic [PROD_W-1:0]       prod;

  logic [1:0]              vld_r;
  logic [FRAC_W-1:0]       frac_r;
  logic [FRAC_W+OUT_W-1:0] plo_r;
  logic [FRAC_W+HI_W-1:0]  phi_r;
  dtfp_side_t              side0_r, side1_r;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_int_r, out_frac_r;
  logic [1:0]       out_status_r;

  // the whole pipe moves whenever the output register can take a beat
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_valid;

  assign scale_idx = CNT_W'(FRAC_DIGITS) - q_rec.frac_count;
  assign scaled    = q_rec.frac_accum * pow10(scale_idx);

  // multiply by the reciprocal as two registered partial products, summed into the output register
  assign prod = {phi_r, {OUT_W{1'b0}}} + PROD_W'(plo_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      frac_r           <= scaled[FRAC_W-1:0];
      side0_r.int_part <= q_rec.int_part;
      side0_r.bad      <= q_rec.bad;
      side0_r.ovf      <= q_rec.ovf;
      plo_r            <= frac_r * REC_LO;
      phi_r            <= frac_r * REC_HI;
      side1_r          <= side0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (side1_r.bad) begin
        out_int_r    <= '0;
        out_frac_r   <= '0;
        out_status_r <= ST_BAD;
      end else begin
        out_int_r    <= side1_r.int_part;
        out_frac_r   <= prod[KSH +: OUT_W];
        out_status_r <= side1_r.ovf ? ST_OVF : ST_OK;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_int_part  = out_int_r;
  assign out_frac_part = out_frac_r;
  assign out_status    = out_status_r;

  `DTFP_ASSERT(a_pop_only_on_advance, !q_pop || adv)
  `DTFP_ASSERT(a_frac_below_div, !vld_r[0] || (frac_r < DIV))
  `DTFP_ASSERT(a_prod_in_range, !vld_r[1] || (prod[PROD_W-1:KSH+OUT_W] == '0))
  `DTFP_ASSERT(a_bad_zeroes_value,
               !out_valid_r || out_status_r != ST_BAD ||
               (out_int_r == '0 && out_frac_r == '0))

endmodule

>>> rtl/core/decimal_text_to_fixed_point_unit.sv
// Top level of the decimal text to fixed point unit
// Takes an unsigned ASCII decimal string one byte per beat, ending in a zero
// byte, and returns one result per string: the integer part (saturated at
// 2^INT_WIDTH - 1, low 32 bits shown), the kept fraction digits (at most
// FRAC_DIGITS) as an unsigned Q0.32 value truncated toward zero, and a
// status of ok, bad character or integer overflow. Bytes are taken at one
// per cycle, back to back while the queue has room, set by the combinational
// multiply-by-ten update in the parser. A string's result passes from the
// queue, whose head is scaled into a register of kept digits, to a register
// of two partial products with the reciprocal of 10^FRAC_DIGITS, then as
// their sum into the output register. A two-entry queue sits between parser
// and converter, so a stalled output only holds off input once it fills.
module decimal_text_to_fixed_point_unit import dtfp_pkg::*; #(
  parameter int unsigned INT_WIDTH   = 32,
  parameter int unsigned FRAC_DIGITS = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_char_code,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_int_part,
  output logic [OUT_W-1:0] out_frac_part,
  output logic [1:0]       out_status
);

  logic      q_room, q_push, q_pop, q_valid;
  dtfp_rec_t push_rec, head_rec;

  dtfp_front #(
    .INT_WIDTH   (INT_WIDTH),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .q_room       (q_room),
    .q_push       (q_push),
    .q_rec        (push_rec)
  );

  dtfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_rec   (push_rec),
    .room       (q_room),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_rec   (head_rec)
  );

  dtfp_back #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_rec         (head_rec),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_int_part  (out_int_part),
    .out_frac_part (out_frac_part),
    .out_status    (out_status)
  );

endmodule
